FILE: design/depth_map_splat_and_hole_fill_core_assert.svh
// assertion macros shared by the depth map checker
`ifndef DEPTH_MAP_SPLAT_AND_HOLE_FILL_CORE_ASSERT_SVH
`define DEPTH_MAP_SPLAT_AND_HOLE_FILL_CORE_ASSERT_SVH

// same-cycle implication, off while in reset
`define DMSHF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define DMSHF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/dmshf_pkg.sv
// types, constants and helpers shared by the depth map modules
package dmshf_pkg;

    // image geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);

    // field widths
    localparam int DEPTH_W   = 16;
    localparam int DIM_W     = 7;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int TYPE_W    = 2;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 2;

    // frame epoch kept with every stored entry
    localparam int EPOCH_W = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_STALE = '0;

    // neighbourhood walk: nine positions, centre in the middle
    localparam int NB_W = 4;
    localparam logic [NB_W-1:0] NB_LAST   = NB_W'(8);
    localparam logic [NB_W-1:0] NB_CENTRE = NB_W'(4);
    localparam int CNT_W = 4;
    localparam int SUM_W = DEPTH_W + 3;

    // division by 3, 5 or 8 as multiply by reciprocal and shift
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(1398102);
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(838861);
    localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'(524288);

    // request codes
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_SPLAT = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_READ  = 2'd2;

    // pixel action codes
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FILL  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS      = 2'd2;

    localparam logic [DEPTH_W-1:0] RANGE_LIM_RST = 16'd65535;
    localparam logic [DIM_W-1:0]   DIM_RST       = 7'd64;
    localparam logic [DIM_W-1:0]   DIM_MIN       = 7'd2;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [ROW_W-1:0]   pixel_row;
        logic [COL_W-1:0]   pixel_col;
        logic [DEPTH_W-1:0] sample_depth;
    } req_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] smoothed_depth;
        logic [ACT_W-1:0]   pixel_action;
    } rsp_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [DEPTH_W-1:0] depth;
    } mem_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic sweep_wr;
        logic splat_rd;
        logic splat_wr;
        logic rd_issue;
        logic acc_clear;
        logic res_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_inside;
        logic epoch_full;
        logic sweep_last;
        logic nb_last;
    } ctrl_sts_t;

    // saturate an image dimension to 2..lim
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                input int unsigned lim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_MIN) r = DIM_MIN;
        else if (32'(v) > lim) r = DIM_W'(lim);
        return r;
    endfunction

    // row offset of neighbourhood position k
    function automatic logic signed [1:0] nb_dr(input logic [NB_W-1:0] k);
        logic signed [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2: r = -2'sd1;
            4'd6, 4'd7, 4'd8: r = 2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

    // column offset of neighbourhood position k
    function automatic logic signed [1:0] nb_dc(input logic [NB_W-1:0] k);
        logic signed [1:0] r;
        case (k)
            4'd0, 4'd3, 4'd6: r = -2'sd1;
            4'd2, 4'd5, 4'd8: r = 2'sd1;
            default:          r = 2'sd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/dmshf_ctrl.sv
// controller state machine for the depth map: sequencing and result handshake
module dmshf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic [1:0]            req_type,
    output logic                  req_stall,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output dmshf_pkg::ctrl_cmd_t  cmd,
    input  dmshf_pkg::ctrl_sts_t  sts
);

    localparam logic [2:0] S_SWEEP    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SPLAT_RD = 3'd2;
    localparam logic [2:0] S_SPLAT_WR = 3'd3;
    localparam logic [2:0] S_READ_ISS = 3'd4;
    localparam logic [2:0] S_READ_ACC = 3'd5;
    localparam logic [2:0] S_READ_DIV = 3'd6;
    localparam logic [2:0] S_READ_OUT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       slot_free;

    // the output register can take a new item
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    case (req_type)
                        dmshf_pkg::REQ_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                            if (sts.epoch_full) state_next = S_SWEEP;
                        end
                        dmshf_pkg::REQ_SPLAT:
                        begin
                            if (sts.req_inside) state_next = S_SPLAT_RD;
                        end
                        dmshf_pkg::REQ_READ:
                        begin
                            cmd.acc_clear = 1'b1;
                            state_next = sts.req_inside ? S_READ_ISS : S_READ_OUT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SPLAT_RD:
            begin
                cmd.splat_rd = 1'b1;
                state_next   = S_SPLAT_WR;
            end
            S_SPLAT_WR:
            begin
                cmd.splat_wr = 1'b1;
                state_next   = S_IDLE;
            end
            S_READ_ISS:
            begin
                cmd.rd_issue = 1'b1;
                if (sts.nb_last) state_next = S_READ_ACC;
            end
            S_READ_ACC:
            begin
                state_next = S_READ_DIV;
            end
            S_READ_DIV:
            begin
                state_next = S_READ_OUT;
            end
            S_READ_OUT:
            begin
                if (slot_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.res_load) rsp_valid_next = 1'b1;
        else if (!rsp_stall) rsp_valid_next = 1'b0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: design/dmshf_dpath.sv
// datapath for the depth map: registers, pixel memory, accumulators, divider
module dmshf_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dmshf_pkg::req_t                      req,
    output dmshf_pkg::rsp_t                      rsp,
    input  logic                                 cfg_valid,
    input  logic [dmshf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dmshf_pkg::DEPTH_W-1:0]        cfg_data,
    input  dmshf_pkg::ctrl_cmd_t                 cmd,
    output dmshf_pkg::ctrl_sts_t                 sts
);

    localparam int RW = dmshf_pkg::ROW_W + 2;
    localparam int CW = dmshf_pkg::COL_W + 2;

    // configuration, stored already saturated
    logic [dmshf_pkg::DEPTH_W-1:0] range_lim_reg;
    logic [dmshf_pkg::DIM_W-1:0]   rows_reg;
    logic [dmshf_pkg::DIM_W-1:0]   cols_reg;

    // item and walk state
    dmshf_pkg::req_t               item_reg;
    logic                          inside_reg;
    logic [dmshf_pkg::NB_W-1:0]    nb_reg;
    logic [dmshf_pkg::EPOCH_W-1:0] epoch_reg;
    logic [dmshf_pkg::ADDR_W-1:0]  sweep_reg;

    // memory
    dmshf_pkg::mem_word_t          mem [dmshf_pkg::DEPTH];
    dmshf_pkg::mem_word_t          rdata_reg;
    dmshf_pkg::mem_word_t          wdata;
    logic [dmshf_pkg::ADDR_W-1:0]  mem_addr;
    logic                          mem_we;
    logic                          mem_en;

    // accumulation
    logic                          acc_en_reg;
    logic                          acc_inb_reg;
    logic                          acc_cen_reg;
    logic [dmshf_pkg::CNT_W-1:0]   n_reg;
    logic [dmshf_pkg::CNT_W-1:0]   valid_reg;
    logic [dmshf_pkg::CNT_W-1:0]   empty_reg;
    logic [dmshf_pkg::SUM_W-1:0]   sum_reg;
    logic [dmshf_pkg::DEPTH_W-1:0] centre_reg;

    // divide stage
    logic [dmshf_pkg::PROD_W-1:0]  prod_reg;
    logic                          fill_reg;
    logic                          iso_reg;

    logic                          req_inside;
    logic [dmshf_pkg::ADDR_W-1:0]  item_addr;
    logic signed [RW-1:0]          nb_row;
    logic signed [CW-1:0]          nb_col;
    logic                          nb_inb;
    logic [dmshf_pkg::ADDR_W-1:0]  nb_addr;
    logic [dmshf_pkg::DEPTH_W-1:0] rd_depth;
    logic                          rd_valid;
    logic [dmshf_pkg::DEPTH_W-1:0] splat_depth;
    logic                          sweep_last;
    logic                          cen_empty;
    logic                          fill_next;
    logic                          iso_next;
    logic [dmshf_pkg::RECIP_W-1:0] recip;
    logic [5:0]                    empty_x4;
    logic [5:0]                    n_x3;

    // incoming pixel lies inside the image in use
    assign req_inside = ({1'b0, req.pixel_row} < rows_reg) &&
                        ({1'b0, req.pixel_col} < cols_reg);

    assign item_addr = dmshf_pkg::ADDR_W'(item_reg.pixel_row) *
                       dmshf_pkg::ADDR_W'(dmshf_pkg::MAX_COLS) +
                       dmshf_pkg::ADDR_W'(item_reg.pixel_col);

    // neighbour position for the walk counter
    assign nb_row = signed'({2'b00, item_reg.pixel_row}) + RW'(dmshf_pkg::nb_dr(nb_reg));
    assign nb_col = signed'({2'b00, item_reg.pixel_col}) + CW'(dmshf_pkg::nb_dc(nb_reg));
    assign nb_inb = !nb_row[RW-1] && !nb_col[CW-1] &&
                    (nb_row[RW-2:0] < rows_reg) && (nb_col[CW-2:0] < cols_reg);
    assign nb_addr = dmshf_pkg::ADDR_W'(nb_row[RW-2:0]) *
                     dmshf_pkg::ADDR_W'(dmshf_pkg::MAX_COLS) +
                     dmshf_pkg::ADDR_W'(nb_col[CW-2:0]);

    assign sweep_last = (sweep_reg == dmshf_pkg::ADDR_W'(dmshf_pkg::DEPTH - 1));

    assign sts.req_inside = req_inside;
    assign sts.epoch_full = (epoch_reg == dmshf_pkg::EPOCH_LAST);
    assign sts.sweep_last = sweep_last;
    assign sts.nb_last    = (nb_reg == dmshf_pkg::NB_LAST);

    // depth seen by a read: stale entries or entries at or over the range limit count as empty
    always_comb
    begin
        rd_valid = (rdata_reg.epoch == epoch_reg);
        rd_depth = range_lim_reg;
        if (rd_valid && (rdata_reg.depth < range_lim_reg)) rd_depth = rdata_reg.depth;
    end

    // nearer of clamped sample and stored depth
    always_comb
    begin
        splat_depth = (item_reg.sample_depth < range_lim_reg) ?
                      item_reg.sample_depth : range_lim_reg;
        if (rd_valid && (rdata_reg.depth < splat_depth)) splat_depth = rdata_reg.depth;
    end

    // single memory port: address and write data
    always_comb
    begin
        mem_addr    = nb_addr;
        mem_we      = 1'b0;
        mem_en      = cmd.rd_issue;
        wdata.epoch = epoch_reg;
        wdata.depth = splat_depth;
        if (cmd.sweep_wr)
        begin
            mem_addr    = sweep_reg;
            mem_we      = 1'b1;
            mem_en      = 1'b1;
            wdata.epoch = dmshf_pkg::EPOCH_STALE;
        end
        else if (cmd.splat_rd || cmd.splat_wr)
        begin
            mem_addr = item_addr;
            mem_we   = cmd.splat_wr;
            mem_en   = 1'b1;
        end
    end

    // pixel memory
    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            if (mem_we) mem[mem_addr] <= wdata;
            rdata_reg <= mem[mem_addr];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_lim_reg <= dmshf_pkg::RANGE_LIM_RST;
            rows_reg      <= dmshf_pkg::sat_dim(dmshf_pkg::DIM_RST, dmshf_pkg::MAX_ROWS);
            cols_reg      <= dmshf_pkg::sat_dim(dmshf_pkg::DIM_RST, dmshf_pkg::MAX_COLS);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dmshf_pkg::CFG_RANGE_LIM: range_lim_reg <= cfg_data;
                dmshf_pkg::CFG_ROWS:
                    rows_reg <= dmshf_pkg::sat_dim(cfg_data[dmshf_pkg::DIM_W-1:0],
                                                   dmshf_pkg::MAX_ROWS);
                dmshf_pkg::CFG_COLS:
                    cols_reg <= dmshf_pkg::sat_dim(cfg_data[dmshf_pkg::DIM_W-1:0],
                                                   dmshf_pkg::MAX_COLS);
                default: ;
            endcase
        end
    end

    // frame epoch and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= dmshf_pkg::EPOCH_FIRST;
            sweep_reg <= '0;
        end
        else if (cmd.sweep_wr)
        begin
            sweep_reg <= sweep_last ? '0 : sweep_reg + 1'b1;
            if (sweep_last) epoch_reg <= dmshf_pkg::EPOCH_FIRST;
        end
        else if (cmd.clear)
        begin
            sweep_reg <= '0;
            if (epoch_reg != dmshf_pkg::EPOCH_LAST) epoch_reg <= epoch_reg + 1'b1;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg   <= req;
            inside_reg <= req_inside;
        end
    end

    // walk counter and read pipeline flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg      <= '0;
            acc_en_reg  <= 1'b0;
            acc_inb_reg <= 1'b0;
            acc_cen_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg  <= cmd.rd_issue;
            acc_inb_reg <= nb_inb;
            acc_cen_reg <= (nb_reg == dmshf_pkg::NB_CENTRE);
            if (cmd.acc_clear) nb_reg <= '0;
            else if (cmd.rd_issue) nb_reg <= nb_reg + 1'b1;
        end
    end

    // neighbourhood accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.acc_clear)
        begin
            n_reg     <= '0;
            valid_reg <= '0;
            empty_reg <= '0;
            sum_reg   <= '0;
        end
        else if (acc_en_reg)
        begin
            if (acc_cen_reg)
            begin
                centre_reg <= rd_depth;
            end
            else if (acc_inb_reg)
            begin
                n_reg <= n_reg + 1'b1;
                if (rd_depth < range_lim_reg)
                begin
                    valid_reg <= valid_reg + 1'b1;
                    sum_reg   <= sum_reg + dmshf_pkg::SUM_W'(rd_depth);
                end
                else
                begin
                    empty_reg <= empty_reg + 1'b1;
                end
            end
        end
    end

    // fill and isolation tests, reciprocal of the neighbour count
    always_comb
    begin
        empty_x4  = {empty_reg, 2'b00};
        n_x3      = 6'({n_reg, 1'b0}) + 6'(n_reg);
        cen_empty = (centre_reg >= range_lim_reg);
        fill_next = cen_empty && (n_reg != '0) && ({valid_reg, 1'b0} >= 5'(n_reg));
        iso_next  = !cen_empty && (empty_x4 >= n_x3);
        case (n_reg)
            4'd3:    recip = dmshf_pkg::RECIP_3;
            4'd5:    recip = dmshf_pkg::RECIP_5;
            default: recip = dmshf_pkg::RECIP_8;
        endcase
    end

    // divide stage register
    always_ff @(posedge clk)
    begin
        prod_reg <= dmshf_pkg::PROD_W'(sum_reg) * dmshf_pkg::PROD_W'(recip);
        fill_reg <= fill_next;
        iso_reg  <= iso_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            if (!inside_reg)
            begin
                rsp.smoothed_depth <= range_lim_reg;
                rsp.pixel_action   <= dmshf_pkg::ACT_NONE;
            end
            else if (fill_reg)
            begin
                rsp.smoothed_depth <= prod_reg[dmshf_pkg::RECIP_SHIFT +: dmshf_pkg::DEPTH_W];
                rsp.pixel_action   <= dmshf_pkg::ACT_FILL;
            end
            else if (iso_reg)
            begin
                rsp.smoothed_depth <= range_lim_reg;
                rsp.pixel_action   <= dmshf_pkg::ACT_CLEAR;
            end
            else
            begin
                rsp.smoothed_depth <= centre_reg;
                rsp.pixel_action   <= dmshf_pkg::ACT_NONE;
            end
        end
    end

endmodule

FILE: design/depth_map_splat_and_hole_fill_core.sv
// top level of the depth map with splatting and hole filling
//
// Request channel req (req_valid, req_stall) carries one item: clear, splat or
// read of a pixel. Result channel rsp (rsp_valid, rsp_stall) carries one item
// per read: smoothed depth and pixel action. Clears and splats give no result.
// Registers range limit (0), rows in use (1) and columns in use (2) are written
// over cfg_valid, cfg_index, cfg_data; cfg_ready is always high. Write them only when idle.
// Sequence, all from one single-port pixel memory:
//   read   : accept, nine memory reads, accumulate, divide, load into the result
//            register; the next item is taken the cycle after
//   splat  : read-modify-write of the stored entry
//   clear  : each fifteenth clear sweeps the memory
// After reset the block sweeps all 4096 entries and holds
// req_stall high until done. A finished result sits in the output register
// while rsp_stall is high; the block takes further requests meanwhile, and a
// later read waits only at its last step until the register frees up.
module depth_map_splat_and_hole_fill_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  dmshf_pkg::req_t                   req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output dmshf_pkg::rsp_t                   rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dmshf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dmshf_pkg::DEPTH_W-1:0]     cfg_data
);

    dmshf_pkg::ctrl_cmd_t cmd;
    dmshf_pkg::ctrl_sts_t sts;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer
    dmshf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // memory and arithmetic
    dmshf_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: design/dmshf_checker.sv
// port-level checker for the depth map, bound to the top level
`include "depth_map_splat_and_hole_fill_core_assert.svh"

module dmshf_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    input  logic                              req_stall,
    input  dmshf_pkg::req_t                   req,
    input  logic                              rsp_valid,
    input  logic                              rsp_stall,
    input  dmshf_pkg::rsp_t                   rsp
);

    // a waiting result item stays and holds its value
    `DMSHF_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result item changed while stalled")

    // a read keeps the block busy in the following cycle
    `DMSHF_ASSERT_NXT(a_read_busy, clk, rst_n, req_valid && !req_stall && (req.req_type == dmshf_pkg::REQ_READ), req_stall, "read accepted but block idle next cycle")

    // a result item only appears out of a read in progress
    `DMSHF_ASSERT_IMP(a_rsp_from_read, clk, rst_n, $rose(rsp_valid), $past(req_stall), "result item without a read in progress")

endmodule

bind depth_map_splat_and_hole_fill_core dmshf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: tb/sv/depth_map_result_checker.sv
// result checker for the depth map core: own pixel store model, compares every read result
`timescale 1ns / 100ps
module depth_map_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  dmshf_pkg::req_t                 req,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  dmshf_pkg::rsp_t                 rsp,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [dmshf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmshf_pkg::DEPTH_W-1:0]   cfg_data,
    output int                              mismatches,
    output int                              results_due
);

    localparam int REPORT_LIMIT = 10;

    // model of the pixel store
    logic [dmshf_pkg::DEPTH_W-1:0] depth_img [dmshf_pkg::DEPTH];
    logic                          written_tag [dmshf_pkg::DEPTH];
    logic                          frame_tag;

    // model of the registers
    logic [dmshf_pkg::DEPTH_W-1:0] range_lim;
    logic [dmshf_pkg::DIM_W-1:0]   rows_reg;
    logic [dmshf_pkg::DIM_W-1:0]   cols_reg;

    // predicted read results, oldest first
    dmshf_pkg::rsp_t smoothed_q [$];
    int              fault_tally;

    // image dimension as used for border handling
    function automatic int dim_in_use(input logic [dmshf_pkg::DIM_W-1:0] v, input int lim);
        if (v < dmshf_pkg::DIM_MIN)
            return dmshf_pkg::DIM_MIN;
        if (int'(v) > lim)
            return lim;
        return v;
    endfunction

    // depth of a pixel as a read sees it
    function automatic logic [dmshf_pkg::DEPTH_W-1:0] seen_depth(input int r, input int c);
        int idx;
        idx = r * dmshf_pkg::MAX_COLS + c;
        if (written_tag[idx] != frame_tag)
            return range_lim;
        return (depth_img[idx] < range_lim) ? depth_img[idx] : range_lim;
    endfunction

    // smoothed depth and action for a read of pixel (r, c)
    function automatic dmshf_pkg::rsp_t smooth_pixel(input int r, input int c);
        dmshf_pkg::rsp_t               res;
        int                            rows_eff;
        int                            cols_eff;
        int                            nr;
        int                            nc;
        int                            n_nb;
        int                            n_valid;
        int                            n_empty;
        int unsigned                   nb_total;
        logic [dmshf_pkg::DEPTH_W-1:0] d;
        logic [dmshf_pkg::DEPTH_W-1:0] centre;
        rows_eff = dim_in_use(rows_reg, dmshf_pkg::MAX_ROWS);
        cols_eff = dim_in_use(cols_reg, dmshf_pkg::MAX_COLS);
        n_nb     = 0;
        n_valid  = 0;
        n_empty  = 0;
        nb_total = 0;
        res.smoothed_depth = range_lim;
        res.pixel_action   = dmshf_pkg::ACT_NONE;
        // pixel outside the image in use
        if (r >= rows_eff || c >= cols_eff)
            return res;
        // walk the in-bounds neighbours
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                nr = r + dr;
                nc = c + dc;
                if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0
                    && nr < rows_eff && nc < cols_eff)
                begin
                    n_nb++;
                    d = seen_depth(nr, nc);
                    if (d < range_lim)
                    begin
                        n_valid++;
                        nb_total += d;
                    end
                    else
                        n_empty++;
                end
            end
        end
        centre = seen_depth(r, c);
        res.smoothed_depth = centre;
        // hole fill or isolated pixel removal
        if (centre >= range_lim)
        begin
            if (n_nb != 0 && 2 * n_valid >= n_nb)
            begin
                res.smoothed_depth = dmshf_pkg::DEPTH_W'(nb_total / n_nb);
                res.pixel_action   = dmshf_pkg::ACT_FILL;
            end
        end
        else if (4 * n_empty >= 3 * n_nb)
        begin
            res.smoothed_depth = range_lim;
            res.pixel_action   = dmshf_pkg::ACT_CLEAR;
        end
        return res;
    endfunction

    // count a failure, print only the first few
    task automatic note_fault(input string what, input dmshf_pkg::rsp_t want,
                              input dmshf_pkg::rsp_t got);
        fault_tally++;
        if (fault_tally <= REPORT_LIMIT)
            $display("%0t: %s: expected depth %0d action %0d, got depth %0d action %0d",
                     $realtime, what, want.smoothed_depth, want.pixel_action,
                     got.smoothed_depth, got.pixel_action);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        dmshf_pkg::rsp_t               want;
        int                            idx;
        int                            rows_eff;
        int                            cols_eff;
        logic [dmshf_pkg::DEPTH_W-1:0] new_d;
        if (!rst_n)
        begin
            for (int k = 0; k < dmshf_pkg::DEPTH; k++)
                written_tag[k] = 1'b0;
            frame_tag   = 1'b1;
            range_lim   = dmshf_pkg::RANGE_LIM_RST;
            rows_reg    = dmshf_pkg::DIM_RST;
            cols_reg    = dmshf_pkg::DIM_RST;
            smoothed_q.delete();
            fault_tally = 0;
            mismatches  <= 0;
            results_due <= 0;
        end
        else
        begin
            // result item against the oldest prediction
            if (rsp_valid && !rsp_stall)
            begin
                if (smoothed_q.size() == 0)
                begin
                    want = '0;
                    note_fault("result with nothing outstanding", want, rsp);
                end
                else
                begin
                    want = smoothed_q.pop_front();
                    if (rsp.smoothed_depth !== want.smoothed_depth
                        || rsp.pixel_action !== want.pixel_action)
                        note_fault("read result mismatch", want, rsp);
                end
            end

            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dmshf_pkg::CFG_RANGE_LIM: range_lim = cfg_data;
                    dmshf_pkg::CFG_ROWS:      rows_reg  = cfg_data[dmshf_pkg::DIM_W-1:0];
                    dmshf_pkg::CFG_COLS:      cols_reg  = cfg_data[dmshf_pkg::DIM_W-1:0];
                    default:                  ;
                endcase
            end

            // request item
            if (req_valid && !req_stall)
            begin
                rows_eff = dim_in_use(rows_reg, dmshf_pkg::MAX_ROWS);
                cols_eff = dim_in_use(cols_reg, dmshf_pkg::MAX_COLS);
                case (req.req_type)
                    dmshf_pkg::REQ_CLEAR:
                    begin
                        frame_tag = ~frame_tag;
                        for (int k = 0; k < dmshf_pkg::DEPTH; k++)
                            written_tag[k] = ~frame_tag;
                    end
                    dmshf_pkg::REQ_SPLAT:
                    begin
                        // keep the nearer depth, ignore pixels outside the image
                        if (req.pixel_row < rows_eff && req.pixel_col < cols_eff)
                        begin
                            idx   = req.pixel_row * dmshf_pkg::MAX_COLS + req.pixel_col;
                            new_d = (req.sample_depth < range_lim) ? req.sample_depth
                                                                   : range_lim;
                            if (written_tag[idx] == frame_tag && depth_img[idx] < new_d)
                                new_d = depth_img[idx];
                            depth_img[idx]   = new_d;
                            written_tag[idx] = frame_tag;
                        end
                    end
                    dmshf_pkg::REQ_READ:
                        smoothed_q = {smoothed_q, smooth_pixel(req.pixel_row, req.pixel_col)};
                    default: ;
                endcase
            end

            mismatches  <= fault_tally;
            results_due <= smoothed_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_depth_map_splat_and_hole_fill_core.sv
// testbench top for the depth map core: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_depth_map_splat_and_hole_fill_core;

    localparam logic [dmshf_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET   = 1700;
    localparam int PHASES        = 9;
    localparam int HOLD_CYCLES   = 400;
    localparam int BURST_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 32;
    localparam int ANCHOR_EVERY  = 50;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_stall;
    dmshf_pkg::req_t                 req       = '0;
    logic                            rsp_valid;
    logic                            rsp_stall = 1'b0;
    dmshf_pkg::rsp_t                 rsp;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dmshf_pkg::CFG_IDX_W-1:0] cfg_index = dmshf_pkg::CFG_RANGE_LIM;
    logic [dmshf_pkg::DEPTH_W-1:0]   cfg_data  = '0;

    int   mismatches;
    int   results_due;
    int   req_gap_pct   = 0;
    int   rsp_stall_pct = 0;
    int   items_sent    = 0;
    int   hold_left     = 0;
    logic hold_go       = 1'b0;
    logic sender_burst  = 1'b0;

    // register settings per phase, the last one drawn at random
    logic [dmshf_pkg::DEPTH_W-1:0] phase_range [PHASES] = '{16'd65535, 16'd1000, 16'd65535,
                                                            16'd0, 16'd1, 16'd40000,
                                                            16'd500, 16'd65535, 16'd0};
    logic [dmshf_pkg::DIM_W-1:0]   phase_rows  [PHASES] = '{7'd64, 7'd8, 7'd2, 7'd64,
                                                            7'd127, 7'd3, 7'd1, 7'd64,
                                                            7'd0};
    logic [dmshf_pkg::DIM_W-1:0]   phase_cols  [PHASES] = '{7'd64, 7'd8, 7'd2, 7'd64,
                                                            7'd0, 7'd64, 7'd65, 7'd64,
                                                            7'd0};

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    depth_map_splat_and_hole_fill_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    depth_map_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    // result side stall: random, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    function automatic dmshf_pkg::req_t pack_req(input logic [dmshf_pkg::TYPE_W-1:0] kind,
                                                 input int r, input int c, input int d);
        dmshf_pkg::req_t it;
        it.req_type     = kind;
        it.pixel_row    = dmshf_pkg::ROW_W'(r);
        it.pixel_col    = dmshf_pkg::COL_W'(c);
        it.sample_depth = dmshf_pkg::DEPTH_W'(d);
        return it;
    endfunction

    // corner of a 5x5 window: image start, far border, or anywhere
    function automatic int pick_anchor(input logic [dmshf_pkg::DIM_W-1:0] dim);
        int span;
        span = (dim > dmshf_pkg::MAX_ROWS) ? dmshf_pkg::MAX_ROWS : dim;
        case ($urandom_range(3))
            0:       return 0;
            1:       return (span > 4) ? span - 4 : 0;
            2:       return $urandom_range(63);
            default: return (span > 6) ? $urandom_range(span - 6) : 0;
        endcase
    endfunction

    // mostly splats and reads clustered in a window, a few clears and unused codes
    function automatic dmshf_pkg::req_t random_item(input int ar, input int ac,
                                                    input logic [dmshf_pkg::DEPTH_W-1:0] lim);
        dmshf_pkg::req_t it;
        int              pick;
        pick = $urandom_range(99);
        if (pick < 3)
            it.req_type = dmshf_pkg::REQ_CLEAR;
        else if (pick < 6)
            it.req_type = REQ_UNUSED;
        else if (pick < 52)
            it.req_type = dmshf_pkg::REQ_SPLAT;
        else
            it.req_type = dmshf_pkg::REQ_READ;
        if ($urandom_range(3) != 0)
        begin
            it.pixel_row = dmshf_pkg::ROW_W'(ar + $urandom_range(4));
            it.pixel_col = dmshf_pkg::COL_W'(ac + $urandom_range(4));
        end
        else
        begin
            it.pixel_row = dmshf_pkg::ROW_W'($urandom);
            it.pixel_col = dmshf_pkg::COL_W'($urandom);
        end
        case ($urandom_range(9))
            0:       it.sample_depth = '0;
            1:       it.sample_depth = '1;
            2:       it.sample_depth = lim;
            3:       it.sample_depth = lim - 1'b1;
            4:       it.sample_depth = dmshf_pkg::DEPTH_W'($urandom);
            default: it.sample_depth = dmshf_pkg::DEPTH_W'($urandom_range(int'(lim)));
        endcase
        return it;
    endfunction

    // offer one request item and wait until it is taken
    task automatic send_item(input dmshf_pkg::req_t it);
        if (items_sent < ITEM_TARGET / 3)
        begin
            req_gap_pct = 27;
            rsp_stall_pct <= 65;
        end
        else if (items_sent < 2 * ITEM_TARGET / 3)
        begin
            req_gap_pct = 65;
            rsp_stall_pct <= 27;
        end
        else
        begin
            req_gap_pct = 0;
            rsp_stall_pct <= 0;
        end
        if (sender_burst)
            req_gap_pct = 0;
        while ($urandom_range(99) < req_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [dmshf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dmshf_pkg::DEPTH_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // stop sending until every read result is back, then let the block settle
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        dmshf_pkg::req_t it;
        int              ar;
        int              ac;
        int              done;
        int              tried;
        int              per_phase;
        phase_range[PHASES-1] = dmshf_pkg::DEPTH_W'($urandom_range(65535, 1));
        phase_rows[PHASES-1]  = dmshf_pkg::DIM_W'($urandom);
        phase_cols[PHASES-1]  = dmshf_pkg::DIM_W'($urandom);
        ar = 0;
        ac = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // corner: empty without neighbours, then filled from two of three
        send_item(pack_req(dmshf_pkg::REQ_READ, 0, 0, 0));
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 0, 1, 100));
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 1, 0, 200));
        send_item(pack_req(dmshf_pkg::REQ_READ, 0, 0, 0));
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 0, 0, 0));
        send_item(pack_req(dmshf_pkg::REQ_READ, 0, 0, 0));
        // far corner: full-scale sample counts as empty, fill needs two valid
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 63, 63, 65535));
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 63, 62, 700));
        send_item(pack_req(dmshf_pkg::REQ_READ, 63, 63, 0));
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 62, 63, 300));
        send_item(pack_req(dmshf_pkg::REQ_READ, 63, 63, 0));
        // interior: isolated pixel, nearer depth kept, exactly three quarters empty
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 32, 40, 5000));
        send_item(pack_req(dmshf_pkg::REQ_READ, 32, 40, 0));
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 32, 40, 9000));
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 32, 41, 4000));
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 31, 40, 4500));
        send_item(pack_req(dmshf_pkg::REQ_READ, 32, 40, 0));
        send_item(pack_req(dmshf_pkg::REQ_SPLAT, 33, 39, 4200));
        send_item(pack_req(dmshf_pkg::REQ_READ, 32, 40, 0));
        // top edge, unused request code, clear
        send_item(pack_req(dmshf_pkg::REQ_READ, 0, 40, 0));
        send_item(pack_req(REQ_UNUSED, 63, 63, 65535));
        send_item(pack_req(dmshf_pkg::REQ_CLEAR, 0, 0, 0));
        send_item(pack_req(dmshf_pkg::REQ_READ, 0, 0, 0));
        send_item(pack_req(dmshf_pkg::REQ_READ, 32, 40, 0));

        // receiver holds off while reads keep coming
        req_valid <= 1'b0;
        hold_go   <= 1'b1;
        @(posedge clk);
        hold_go   <= 1'b0;
        sender_burst = 1'b1;
        for (int k = 0; k < BURST_ITEMS; k++)
            send_item(pack_req((k % 2) ? dmshf_pkg::REQ_READ : dmshf_pkg::REQ_SPLAT,
                               31 + k % 3, 39 + k % 4, 1000 + 37 * k));
        sender_burst = 1'b0;
        wait_idle();

        // random phases, one register setting each
        per_phase = ITEM_TARGET / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(dmshf_pkg::CFG_RANGE_LIM, phase_range[p]);
            write_reg(dmshf_pkg::CFG_ROWS, {9'($urandom), phase_rows[p]});
            write_reg(dmshf_pkg::CFG_COLS, {9'($urandom), phase_cols[p]});
            cfg_valid <= 1'b0;
            done  = 0;
            tried = 0;
            while (done < per_phase)
            begin
                if (tried % ANCHOR_EVERY == 0)
                begin
                    ar = pick_anchor(phase_rows[p]);
                    ac = pick_anchor(phase_cols[p]);
                end
                it = random_item(ar, ac, phase_range[p]);
                send_item(it);
                tried++;
                if (it.req_type != REQ_UNUSED)
                    done++;
            end
            // closing read, its result comes after all earlier work
            send_item(pack_req(dmshf_pkg::REQ_READ, $urandom_range(63), $urandom_range(63),
                               $urandom));
            wait_idle();
        end

        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #(8_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
